FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when ante holds, cons holds on the same edge.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("%m: same-cycle implication failed");

// Next-cycle implication: when ante holds, cons holds on the following edge.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("%m: next-cycle implication failed");

`endif

FILE: rtl/core/vl2n_pkg.sv
// ----------------------------------------------------------------------------
// vl2n_pkg
// Types and constants shared by the L2 vector normaliser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package vl2n_pkg;

    localparam int VECTOR_LEN_DEF = 12;
    localparam int FRAC_BITS_DEF  = 15;

    localparam int SAMPLE_W = 16;
    localparam int INDEX_W  = 6;
    localparam int SQ_W     = 2 * SAMPLE_W;
    localparam int SUM_W    = 36;
    localparam int ROOT_W   = SUM_W / 2;
    // Partial remainder of both the root and the divide iterations.
    localparam int REM_W    = ROOT_W + 2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACC,
        ST_SQRT,
        ST_LOAD,
        ST_DIV,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                last;
    } t_in;

    typedef struct packed {
        logic [SAMPLE_W-1:0] norm_value;
        logic [INDEX_W-1:0]  index;
        logic                last_res;
    } t_out;

endpackage

FILE: rtl/core/vl2n_cmp_sub.sv
// ----------------------------------------------------------------------------
// vl2n_cmp_sub
// Shared compare-and-subtract step for the root and divide iterations.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vl2n_cmp_sub #(
    parameter int WIDTH = vl2n_pkg::REM_W
) (
    input  logic [WIDTH-1:0] i_a,
    input  logic [WIDTH-1:0] i_b,
    output logic [WIDTH-1:0] o_diff,
    output logic             o_ge
);
    import vl2n_pkg::*;

    logic [WIDTH:0] diff_ext;

    // Borrow out of the extended subtract clear means a >= b.
    assign diff_ext = {1'b0, i_a} - {1'b0, i_b};
    assign o_diff   = diff_ext[WIDTH-1:0];
    assign o_ge     = ~diff_ext[WIDTH];

endmodule

FILE: rtl/core/vector_l2_normalizer_unit.sv
// ----------------------------------------------------------------------------
// vector_l2_normalizer_unit
// L2 normalisation of an unsigned 16-bit vector. A start beat is taken while
// busy is low; a sample without the last mark is accepted and accumulated,
// and the block is then idle again. The beat marked last is accepted and
// accumulated, then passes through a bit-pair square root and, per stored
// element, a registered memory read, a restoring divide by the root and an
// emit. Both the root and every divide step run through one shared
// compare-subtract unit. Results appear one per strobe, index 0 first, the
// final one carrying last_res; the receiver cannot stall, so hold nothing back:
// each o_strobe beat must be taken in that cycle. busy drops in the very cycle
// that shows the final result, so a new beat may be taken at its closing edge.
// Samples beyond VECTOR_LEN before the last mark are dropped; an all-zero
// vector yields zeros.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vector_l2_normalizer_unit #(
    parameter int VECTOR_LEN = vl2n_pkg::VECTOR_LEN_DEF,
    parameter int FRAC_BITS  = vl2n_pkg::FRAC_BITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  vl2n_pkg::t_in   i_data,
    output logic            o_strobe,
    output vl2n_pkg::t_out  o_data
);
    import vl2n_pkg::*;

    localparam int ADDR_W = $clog2(VECTOR_LEN);
    localparam int CNT_W  = $clog2(VECTOR_LEN + 1);
    // Dividend is the sample shifted up by the fraction width.
    localparam int DIV_W  = SAMPLE_W + FRAC_BITS;
    localparam int STEP_W = $clog2(DIV_W);

    typedef struct packed {
        logic acc_en;
        logic sqrt_en;
        logic load_en;
        logic div_en;
        logic emit_en;
    } t_ctrl;

    t_state              r_state, n_state;
    t_ctrl               ctrl;

    logic [SAMPLE_W-1:0] r_sample;
    logic                r_last;
    logic [SUM_W-1:0]    r_sum;
    logic [CNT_W-1:0]    r_cnt;
    logic [ADDR_W-1:0]   r_idx;
    logic [STEP_W-1:0]   r_step;
    logic [REM_W-1:0]    r_rem;
    logic [ROOT_W-1:0]   r_root;
    logic [DIV_W-1:0]    r_dq;
    logic                r_strobe;
    t_out                r_out;

    logic [SAMPLE_W-1:0] r_mem [VECTOR_LEN];

    logic                accept;
    logic [SQ_W-1:0]     square;
    logic [SUM_W:0]      sum_ext;
    logic [SUM_W-1:0]    n_sum;
    logic                room;
    logic                is_last;
    logic                root_done;
    logic                div_done;
    logic [REM_W-1:0]    cs_a, cs_b, cs_diff;
    logic                cs_ge;
    logic [SAMPLE_W-1:0] quot_sat;

    assign accept = start && (r_state == ST_IDLE);
    assign busy   = (r_state != ST_IDLE);

    // Accumulate: square the held sample and saturate the running sum.
    assign square  = r_sample * r_sample;
    assign sum_ext = {1'b0, r_sum} + (SUM_W + 1)'(square);
    assign n_sum   = sum_ext[SUM_W] ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];
    assign room    = (r_cnt < CNT_W'(VECTOR_LEN));

    assign is_last   = ((CNT_W'(r_idx) + CNT_W'(1)) == r_cnt);
    assign root_done = (r_step == STEP_W'(ROOT_W - 1));
    assign div_done  = (r_step == STEP_W'(DIV_W - 1));

    // Operand select for the shared unit: bit-pair root step or
    // restoring divide step by the root.
    always_comb begin
        if (ctrl.sqrt_en) begin
            cs_a = {r_rem[REM_W-3:0], r_sum[SUM_W-1 -: 2]};
            cs_b = {r_root, 2'b01};
        end else begin
            cs_a = {r_rem[REM_W-2:0], r_dq[DIV_W-1]};
            cs_b = {2'b00, r_root};
        end
    end

    vl2n_cmp_sub #(
        .WIDTH (REM_W)
    ) u_cmp_sub (
        .i_a    (cs_a),
        .i_b    (cs_b),
        .o_diff (cs_diff),
        .o_ge   (cs_ge)
    );

    // Clamp quotients that spill past 16 bits (wide fractions only).
    assign quot_sat = (|r_dq[DIV_W-1:SAMPLE_W]) ? {SAMPLE_W{1'b1}}
                                                : r_dq[SAMPLE_W-1:0];

    // Sequencer: next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_ACC;
                end
            end
            ST_ACC: begin
                n_state = r_last ? ST_SQRT : ST_IDLE;
            end
            ST_SQRT: begin
                if (root_done) begin
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: begin
                n_state = ST_DIV;
            end
            ST_DIV: begin
                if (div_done) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                n_state = is_last ? ST_IDLE : ST_LOAD;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Sequencer: datapath controls.
    always_comb begin
        ctrl = '0;
        case (r_state)
            ST_ACC:  ctrl.acc_en  = 1'b1;
            ST_SQRT: ctrl.sqrt_en = 1'b1;
            ST_LOAD: ctrl.load_en = 1'b1;
            ST_DIV:  ctrl.div_en  = 1'b1;
            ST_EMIT: ctrl.emit_en = 1'b1;
            default: ctrl = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_sum    <= '0;
            r_cnt    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= ctrl.emit_en;
            if (ctrl.acc_en && room) begin
                r_sum <= n_sum;
                r_cnt <= r_cnt + CNT_W'(1);
            end
            // Shift the sum out two bits per root step; it ends at zero.
            if (ctrl.sqrt_en) begin
                r_sum <= {r_sum[SUM_W-3:0], 2'b00};
            end
            if (ctrl.emit_en && is_last) begin
                r_cnt <= '0;
            end
        end
    end

    // Payload registers: no reset.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_sample <= i_data.sample;
            r_last   <= i_data.last;
        end
        if (ctrl.acc_en) begin
            r_rem  <= '0;
            r_root <= '0;
            r_step <= '0;
            r_idx  <= '0;
        end
        if (ctrl.sqrt_en) begin
            r_rem  <= cs_ge ? cs_diff : cs_a;
            r_root <= {r_root[ROOT_W-2:0], cs_ge};
            r_step <= r_step + STEP_W'(1);
        end
        // Registered read of the element store into the dividend.
        if (ctrl.load_en) begin
            r_rem  <= '0;
            r_step <= '0;
            r_dq   <= {r_mem[r_idx], {FRAC_BITS{1'b0}}};
        end
        if (ctrl.div_en) begin
            r_rem  <= cs_ge ? cs_diff : cs_a;
            r_dq   <= {r_dq[DIV_W-2:0], cs_ge};
            r_step <= r_step + STEP_W'(1);
        end
        if (ctrl.emit_en) begin
            r_out.norm_value <= (|r_root) ? quot_sat : '0;
            r_out.index      <= INDEX_W'(r_idx);
            r_out.last_res   <= is_last;
            r_idx            <= r_idx + ADDR_W'(1);
        end
    end

    // Element store: write on accumulate.
    always_ff @(posedge i_clk) begin
        if (ctrl.acc_en && room) begin
            r_mem[r_cnt[ADDR_W-1:0]] <= r_sample;
        end
    end

    assign o_strobe = r_strobe;
    assign o_data   = r_out;

endmodule

FILE: rtl/core/vl2n_checker.sv
// ----------------------------------------------------------------------------
// vl2n_checker
// Port-level checks on the L2 vector normaliser, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module vl2n_port_checker #(
    parameter int VECTOR_LEN = vl2n_pkg::VECTOR_LEN_DEF,
    parameter int FRAC_BITS  = vl2n_pkg::FRAC_BITS_DEF
) (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           start,
    input logic           busy,
    input logic           o_strobe,
    input vl2n_pkg::t_out o_data
);
    import vl2n_pkg::*;

    localparam int MAX_NORM = (FRAC_BITS >= SAMPLE_W) ? (2 ** SAMPLE_W) - 1
                                                      : 2 ** FRAC_BITS;

    // Normalised value never exceeds unity (or the 16-bit clamp).
    `ASSERT_IMPL(a_norm_range, i_clk, i_rst_n, o_strobe, (int'(o_data.norm_value) <= MAX_NORM))
    // Index stays inside the vector.
    `ASSERT_IMPL(a_index_range, i_clk, i_rst_n, o_strobe, (int'(o_data.index) < VECTOR_LEN))
    // More results pending keep the block busy.
    `ASSERT_IMPL(a_busy_mid, i_clk, i_rst_n, o_strobe && !o_data.last_res, busy)
    // Closing result is never followed straight away by another.
    `ASSERT_NEXT(a_gap_after_last, i_clk, i_rst_n, o_strobe && o_data.last_res, !o_strobe)
    // Every accepted beat holds busy for its accumulate cycle.
    `ASSERT_NEXT(a_busy_after_beat, i_clk, i_rst_n, start && !busy, busy)

endmodule

bind vector_l2_normalizer_unit vl2n_port_checker #(
    .VECTOR_LEN (VECTOR_LEN),
    .FRAC_BITS  (FRAC_BITS)
) u_vl2n_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_strobe (o_strobe),
    .o_data   (o_data)
);
